FILE: sv/bftd_pkg.sv
package bftd_pkg;

	// Output fields report tape positions in this many bits.
	localparam int HEAD_W = 10;
	localparam int BYTE_W = 8;

	typedef enum logic [2:0] {
		KIND_LOOP_START = 3'd0,
		KIND_LOOP_END   = 3'd1,
		KIND_LEFT       = 3'd2,
		KIND_RIGHT      = 3'd3,
		KIND_INCREMENT  = 3'd4,
		KIND_DECREMENT  = 3'd5,
		KIND_INPUT      = 3'd6,
		KIND_OUTPUT     = 3'd7
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [BYTE_W-1:0]  key_byte;
	} op_t;

	typedef struct packed {
		logic               take_jump;
		logic               out_valid;
		logic [BYTE_W-1:0]  out_byte;
		logic [HEAD_W-1:0]  head_position;
		logic [BYTE_W-1:0]  cell_value;
		logic [HEAD_W-1:0]  furthest_cell;
		logic               overrun;
	} res_t;

endpackage

FILE: sv/bftd_ram.sv
module bftd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: sv/bftd_exec.sv
module bftd_exec import bftd_pkg::*; #(
	parameter int TAPE_CELLS = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  op_t  op,
	output res_t res
);

	localparam int AW = $clog2(TAPE_CELLS);
	localparam logic [AW-1:0] LAST_IDX = AW'(TAPE_CELLS - 1);

	// The cell under the head and its two neighbors are held in registers.
	// A neighbor refilled from the tape memory arrives in the cycle after a move
	// and is taken straight from the memory output while its select is set.
	logic [AW-1:0]     head_q, fur_q, head_n, fur_n;
	logic [BYTE_W-1:0] cur_q, lft_q, rgt_q, far_q;
	logic [BYTE_W-1:0] cur_n, lft_n, rgt_n, far_n;
	logic              lft_sel_q, rgt_sel_q, lft_sel_n, rgt_sel_n;
	logic [BYTE_W-1:0] lft_eff, rgt_eff, rd_data, wr_data;
	logic [AW-1:0]     rd_addr, wr_addr, head_inc, head_dec;
	logic              rd_en, wr_en, at_fur, at_last;
	logic              jump, emit, refused;

	assign lft_eff  = lft_sel_q ? rd_data : lft_q;
	assign rgt_eff  = rgt_sel_q ? rd_data : rgt_q;
	assign head_inc = head_q + 1'b1;
	assign head_dec = head_q - 1'b1;
	assign at_fur   = (head_q == fur_q);
	assign at_last  = (head_q == LAST_IDX);

	always_comb begin
		head_n    = head_q;
		fur_n     = fur_q;
		cur_n     = cur_q;
		lft_n     = lft_eff;
		rgt_n     = rgt_eff;
		far_n     = far_q;
		lft_sel_n = 1'b0;
		rgt_sel_n = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = head_q;
		wr_data   = cur_q;
		rd_en     = 1'b0;
		rd_addr   = head_q;
		jump      = 1'b0;
		emit      = 1'b0;
		refused   = 1'b0;
		if (en) begin
			case (op.kind)
				KIND_LOOP_START: begin
					jump = (cur_q == '0);
				end
				KIND_LOOP_END: begin
					jump = (cur_q != '0);
				end
				KIND_LEFT: begin
					// The cell being left is written back so that a later refill reads it.
					wr_en = 1'b1;
					if (head_q != '0) begin
						head_n = head_dec;
						cur_n  = lft_eff;
						rgt_n  = cur_q;
						if (head_dec != '0) begin
							rd_en     = 1'b1;
							rd_addr   = head_dec - 1'b1;
							lft_sel_n = 1'b1;
						end else begin
							lft_n = '0;
						end
					end else begin
						// Wrapping lands on the furthest mark, whose right side is unvisited.
						head_n = fur_q;
						cur_n  = far_q;
						rgt_n  = '0;
						if (fur_q != '0) begin
							rd_en     = 1'b1;
							rd_addr   = fur_q - 1'b1;
							lft_sel_n = 1'b1;
						end else begin
							lft_n = '0;
						end
					end
				end
				KIND_RIGHT: begin
					if (at_last) begin
						refused = 1'b1;
					end else begin
						wr_en  = 1'b1;
						head_n = head_inc;
						cur_n  = rgt_eff;
						lft_n  = cur_q;
						if (at_fur) begin
							// A newly reached cell has never been written and is zero.
							fur_n = head_inc;
							far_n = '0;
						end
						if (fur_q > head_inc) begin
							rd_en     = 1'b1;
							rd_addr   = head_inc + 1'b1;
							rgt_sel_n = 1'b1;
						end else begin
							rgt_n = '0;
						end
					end
				end
				KIND_INCREMENT: begin
					cur_n   = cur_q + 1'b1;
					wr_en   = 1'b1;
					wr_data = cur_n;
					if (at_fur) begin
						far_n = cur_n;
					end
				end
				KIND_DECREMENT: begin
					cur_n   = cur_q - 1'b1;
					wr_en   = 1'b1;
					wr_data = cur_n;
					if (at_fur) begin
						far_n = cur_n;
					end
				end
				KIND_INPUT: begin
					cur_n   = op.key_byte;
					wr_en   = 1'b1;
					wr_data = cur_n;
					if (at_fur) begin
						far_n = cur_n;
					end
				end
				KIND_OUTPUT: begin
					emit = 1'b1;
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			fur_q     <= '0;
			cur_q     <= '0;
			lft_q     <= '0;
			rgt_q     <= '0;
			far_q     <= '0;
			lft_sel_q <= 1'b0;
			rgt_sel_q <= 1'b0;
		end else begin
			head_q    <= head_n;
			fur_q     <= fur_n;
			cur_q     <= cur_n;
			lft_q     <= lft_n;
			rgt_q     <= rgt_n;
			far_q     <= far_n;
			lft_sel_q <= lft_sel_n;
			rgt_sel_q <= rgt_sel_n;
		end
	end

	bftd_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(TAPE_CELLS)
	) u_tape (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign res.take_jump     = jump;
	assign res.out_valid     = emit;
	assign res.out_byte      = emit ? cur_q : '0;
	assign res.head_position = HEAD_W'(head_n);
	assign res.cell_value    = cur_n;
	assign res.furthest_cell = HEAD_W'(fur_n);
	assign res.overrun       = refused;

	a_head_within_mark: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= fur_q)
		else $error("head passed the furthest mark");

	a_mark_on_tape: assert property (@(posedge clk) disable iff (!arst_n)
		fur_q <= LAST_IDX)
		else $error("furthest mark beyond the last cell");

	a_right_of_mark_zero: assert property (@(posedge clk) disable iff (!arst_n)
		at_fur |-> (rgt_q == '0) && !rgt_sel_q)
		else $error("cell right of the furthest mark is not zero");

	a_mark_advance: assert property (@(posedge clk) disable iff (!arst_n)
		en && (op.kind == KIND_RIGHT) && at_fur && !at_last
		|=> fur_q == $past(head_inc))
		else $error("furthest mark did not follow the head");

endmodule

FILE: sv/brainfuck_tape_datapath_unit.sv
// A command is held in the command register and, once it executes, its response in the response register.
// Throughput: one command per cycle while the response side does not stall; the tape is a one-write, one-read memory.
// A move refills the new neighbor cell from memory while the two adjacent cells stay in registers.
// Reset clears head, furthest mark and all handshake state at once; no clearing pass runs.
// Cells past the furthest mark have not been written since reset and always read as zero.
module brainfuck_tape_datapath_unit import bftd_pkg::*; #(
	parameter int TAPE_CELLS = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  op_t  cmd,
	output logic rsp_valid,
	input  logic rsp_stall,
	output res_t rsp
);

	// The command register holds one transaction; it executes as soon as the
	// response register is empty or being emptied, so the two sides are decoupled
	// by one register each; a new transaction can enter every cycle unless rsp_stall holds.
	logic vld_s1;
	op_t  op_s1;
	logic vld_s2;
	res_t rsp_s2;
	logic fire;
	res_t exec_res;

	assign fire      = vld_s1 && (!vld_s2 || !rsp_stall);
	assign cmd_stall = vld_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (!cmd_stall) begin
				vld_s1 <= cmd_valid;
			end
			if (fire) begin
				vld_s2 <= 1'b1;
			end else if (!rsp_stall) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	// Payload registers need no reset; they are qualified by the valid flags.
	always_ff @(posedge clk) begin
		if (!cmd_stall) begin
			op_s1 <= cmd;
		end
		if (fire) begin
			rsp_s2 <= exec_res;
		end
	end

	// The execute stage updates the tape state only when a transaction fires.
	bftd_exec #(
		.TAPE_CELLS(TAPE_CELLS)
	) u_exec (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (fire),
		.op     (op_s1),
		.res    (exec_res)
	);

	assign rsp_valid = vld_s2;
	assign rsp       = rsp_s2;

	a_fire_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_valid && (rsp == $past(exec_res)))
		else $error("executed transaction did not reach the response register");

endmodule

FILE: bench/brainfuck_tape_datapath_unit_tb.sv
module brainfuck_tape_datapath_unit_tb;
	import bftd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TAPE_LEN = 1024;
	localparam int ITEM_TARGET = 1900;

	// The receiver switches between these stall behaviors at random.
	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_COIN,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	op_t cmd = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	res_t rsp;

	brainfuck_tape_datapath_unit #(
		.TAPE_CELLS(TAPE_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #10 clk = ~clk;

	// Shadow copy of the tape, head and furthest mark, advanced once per accepted
	// command transaction.
	logic [BYTE_W-1:0] tape_shadow [TAPE_LEN];
	int unsigned head_at = 0;
	int unsigned furthest_at = 0;

	op_t queued_ops[$];
	res_t due_results[$];

	int mismatch_count = 0;
	int items_queued = 0;
	int results_seen = 0;
	int jumps_seen = 0;
	int outputs_seen = 0;
	int refusals_seen = 0;
	int wraps_seen = 0;
	int unsigned max_head_seen = 0;

	initial begin
		foreach (tape_shadow[i]) begin
			tape_shadow[i] = '0;
		end
	end

	// Executes one operation against the shadow tape and returns the response the
	// block must produce for it.
	function automatic res_t run_tape_op(op_t c);
		res_t r;
		logic [BYTE_W-1:0] cur;
		r = '0;
		cur = tape_shadow[head_at];
		case (c.kind)
			KIND_LOOP_START: r.take_jump = (cur == '0);
			KIND_LOOP_END:   r.take_jump = (cur != '0);
			KIND_LEFT: begin
				// Stepping left off cell zero lands on the furthest cell reached.
				if (head_at == 0) begin
					head_at = furthest_at;
					wraps_seen++;
				end else begin
					head_at = head_at - 1;
				end
			end
			KIND_RIGHT: begin
				// The last cell refuses the move; the head and mark stay put.
				if (head_at == TAPE_LEN - 1) begin
					r.overrun = 1'b1;
				end else begin
					if (furthest_at == head_at) begin
						furthest_at = head_at + 1;
					end
					head_at = head_at + 1;
				end
			end
			KIND_INCREMENT: tape_shadow[head_at] = cur + 1'b1;
			KIND_DECREMENT: tape_shadow[head_at] = cur - 1'b1;
			KIND_INPUT:     tape_shadow[head_at] = c.key_byte;
			KIND_OUTPUT: begin
				r.out_valid = 1'b1;
				r.out_byte = cur;
			end
			default: begin
			end
		endcase
		r.head_position = HEAD_W'(head_at);
		r.cell_value = tape_shadow[head_at];
		r.furthest_cell = HEAD_W'(furthest_at);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatch_count++;
	endtask

	function automatic op_t make_op(kind_t k);
		op_t o;
		o.kind = k;
		// Every operation carries a random key so that all key bits toggle, even
		// on operations that must ignore it.
		o.key_byte = BYTE_W'($urandom_range(0, 255));
		return o;
	endfunction

	// Picks a random operation; move_pct sets the share of head moves.
	function automatic op_t pick_op(int move_pct);
		kind_t cell_kinds[6];
		cell_kinds = '{KIND_LOOP_START, KIND_LOOP_END, KIND_INCREMENT,
			KIND_DECREMENT, KIND_INPUT, KIND_OUTPUT};
		if ($urandom_range(0, 99) < move_pct) begin
			return make_op(($urandom_range(0, 1) != 0) ? KIND_RIGHT : KIND_LEFT);
		end
		return make_op(cell_kinds[$urandom_range(0, 5)]);
	endfunction

	task automatic queue_op(op_t o);
		queued_ops.push_back(o);
		items_queued++;
	endtask

	task automatic queue_kind(kind_t k);
		queue_op(make_op(k));
	endtask

	task automatic queue_input(logic [BYTE_W-1:0] key);
		op_t o;
		o.kind = KIND_INPUT;
		o.key_byte = key;
		queue_op(o);
	endtask

	// Waits on falling edges, where everything updated at the rising edge has
	// settled, until the driver has nothing left and no response is owed.
	task automatic wait_drained();
		while (queued_ops.size() != 0 || cmd_valid || due_results.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Command driver. It sends in bursts of random length separated by random
	// gaps; roughly a third of the bursts are followed by no gap at all, giving
	// stretches of back-to-back transactions. A stalled command is held with its
	// payload untouched until the block takes it.
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				due_results.push_back(run_tape_op(cmd));
			end
			if (!cmd_valid || !cmd_stall) begin
				if (gap_left > 0 || queued_ops.size() == 0) begin
					if (gap_left > 0) begin
						gap_left--;
					end
					cmd_valid <= 1'b0;
				end else begin
					cmd <= queued_ops.pop_front();
					cmd_valid <= 1'b1;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 48);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	// Response monitor. Every accepted response transaction is compared field by
	// field with the oldest owed result. The stall pattern switches at random between
	// modes: no stall, coin flip, a fixed periodic pattern, or heavy.
	stall_mode_t stall_mode = STALL_NONE;
	int stall_left = 0;
	int unsigned stall_tick = 0;

	always @(posedge clk) begin
		res_t want;
		logic next_stall;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (due_results.size() == 0) begin
					report_mismatch("unexpected response", int'(rsp), 0);
				end else begin
					want = due_results.pop_front();
					results_seen++;
					if (want.take_jump) jumps_seen++;
					if (want.out_valid) outputs_seen++;
					if (want.overrun) refusals_seen++;
					if (want.head_position > max_head_seen) begin
						max_head_seen = 32'(want.head_position);
					end
					if (rsp.take_jump !== want.take_jump)
						report_mismatch("take_jump", int'(rsp.take_jump),
							int'(want.take_jump));
					if (rsp.out_valid !== want.out_valid)
						report_mismatch("out_valid", int'(rsp.out_valid),
							int'(want.out_valid));
					if (rsp.out_byte !== want.out_byte)
						report_mismatch("out_byte", int'(rsp.out_byte),
							int'(want.out_byte));
					if (rsp.head_position !== want.head_position)
						report_mismatch("head_position", int'(rsp.head_position),
							int'(want.head_position));
					if (rsp.cell_value !== want.cell_value)
						report_mismatch("cell_value", int'(rsp.cell_value),
							int'(want.cell_value));
					if (rsp.furthest_cell !== want.furthest_cell)
						report_mismatch("furthest_cell", int'(rsp.furthest_cell),
							int'(want.furthest_cell));
					if (rsp.overrun !== want.overrun)
						report_mismatch("overrun", int'(rsp.overrun),
							int'(want.overrun));
				end
			end
			if (stall_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				stall_left = $urandom_range(20, 200);
			end
			stall_left--;
			stall_tick++;
			case (stall_mode)
				STALL_NONE:     next_stall = 1'b0;
				STALL_COIN:     next_stall = 1'($urandom_range(0, 1));
				STALL_PERIODIC: next_stall = (stall_tick % 5) < 2;
				default:        next_stall = ($urandom_range(0, 3) != 0);
			endcase
			rsp_stall <= next_stall;
		end
	end

	// Stimulus and end of run.
	initial begin
		int rights;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part on a fresh tape: loop decisions on a zero and a nonzero
		// cell, wrap of the cell value in both directions, input of the key
		// extremes, left from cell zero while the mark is still at zero, right
		// onto the furthest mark, right from below the mark, and left from cell
		// zero wrapping out to a furthest mark that has moved.
		queue_kind(KIND_LOOP_START);
		queue_kind(KIND_LOOP_END);
		queue_kind(KIND_OUTPUT);
		queue_kind(KIND_DECREMENT);
		queue_kind(KIND_OUTPUT);
		queue_kind(KIND_LOOP_END);
		queue_kind(KIND_LOOP_START);
		queue_kind(KIND_INCREMENT);
		queue_input(8'hFF);
		queue_input(8'h00);
		queue_input(8'hA5);
		queue_input(8'h5A);
		queue_kind(KIND_LEFT);
		queue_kind(KIND_RIGHT);
		queue_input(8'h80);
		queue_kind(KIND_OUTPUT);
		queue_kind(KIND_RIGHT);
		queue_kind(KIND_LEFT);
		queue_kind(KIND_LEFT);
		queue_kind(KIND_LEFT);
		queue_kind(KIND_LEFT);
		queue_kind(KIND_RIGHT);
		queue_kind(KIND_RIGHT);
		queue_kind(KIND_OUTPUT);

		// Hold the sender back until every owed response has come.
		wait_drained();

		// Random walk near the origin: lefts from cell zero keep jumping out to
		// the mark while rights keep pushing it, and cells get revisited often.
		repeat (350) queue_op(pick_op(40));

		// Sprint to the far end of the tape with cell operations mixed in, then
		// keep pushing right so the last cell refuses several moves.
		rights = 0;
		while (rights < TAPE_LEN + 6) begin
			if ($urandom_range(0, 5) == 0) begin
				queue_op(pick_op(0));
			end else begin
				queue_kind(KIND_RIGHT);
				rights++;
			end
		end
		wait_drained();

		// Random operations around the last cell to fill the remaining budget.
		while (items_queued < ITEM_TARGET) begin
			queue_op(pick_op(35));
		end
		wait_drained();

		// Wait on after the drain so that any spurious extra response is caught by the monitor.
		repeat (8) @(negedge clk);
		if (due_results.size() != 0) begin
			report_mismatch("owed responses left", due_results.size(), 0);
		end

		$display("Checked %0d responses: %0d jumps taken, %0d outputs, %0d refused right moves,",
			results_seen, jumps_seen, outputs_seen, refusals_seen);
		$display("%0d left wraps from cell zero, head reached cell %0d.",
			wraps_seen, max_head_seen);
		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Watchdog: a run that hangs is ended and reported as failing.
	initial begin
		#8_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
